// ----- sv/rtpq_pkg.sv -----
// shared types and constants for the radix trie priority queue
package rtpq_pkg;

    localparam int CAPACITY   = 256;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int LINK_W     = IDX_W + 1;
    localparam int KEY_W      = 64;
    localparam int TAG_W      = 32;
    localparam int LEVEL_W    = 7;
    localparam logic [LINK_W-1:0] NIL = LINK_W'(CAPACITY);

    typedef logic [LINK_W-1:0] link_t;

    typedef enum logic [2:0]
    {
        OP_INSERT = 3'd0,
        OP_MODIFY = 3'd1,
        OP_LOOKUP = 3'd2,
        OP_PEEK   = 3'd3,
        OP_POP    = 3'd4,
        OP_DELETE = 3'd5
    } op_t;

    typedef enum logic [2:0]
    {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_DUP      = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    // node record held in one memory word
    typedef struct packed
    {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        link_t            c0;
        link_t            c1;
    } node_t;

endpackage

// ----- sv/radix_trie_priority_queue_unit.sv -----
// radix trie priority queue: node memory, free list memory and walk sequencer
// sequencing: each trie level takes a read issue, then a compare or write; an item walks the
// levels of its key search or minimum walk, then for a pop or delete the levels it removes
// throughput: one item at a time; the next request is taken once the result has been taken
// reset: root null, count zero, free list built by a pass over every entry, no request taken meanwhile
module radix_trie_priority_queue_unit
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,   // op[2:0], key[66:3], tag[98:67], zero pad
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata    // status[2:0], out_key[66:3], out_tag[98:67], pad
);

    typedef enum logic [3:0]
    {
        S_INIT, S_IDLE, S_FRD, S_FIND, S_LINK, S_MRD, S_MIN, S_RRD, S_RMV, S_OUT
    } state_t;

    localparam int IW = rtpq_pkg::IDX_W;
    localparam int LW = rtpq_pkg::LINK_W;
    localparam int KW = rtpq_pkg::KEY_W;
    localparam int TW = rtpq_pkg::TAG_W;

    // memories
    rtpq_pkg::node_t node_mem [rtpq_pkg::CAPACITY];
    rtpq_pkg::link_t free_mem [rtpq_pkg::CAPACITY];
    rtpq_pkg::node_t node_rd;
    rtpq_pkg::link_t free_rd;
    logic            node_we, free_we;
    logic [IW-1:0]   node_wa, node_ra, free_wa, free_ra;
    rtpq_pkg::node_t node_wd;
    rtpq_pkg::link_t free_wd;

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_wa] <= node_wd;
        end
        node_rd <= node_mem[node_ra];
        if (free_we)
        begin
            free_mem[free_wa] <= free_wd;
        end
        free_rd <= free_mem[free_ra];
    end

    // control and working registers
    state_t               state_reg;
    rtpq_pkg::link_t      root_reg, head_reg, count_reg;
    rtpq_pkg::op_t        op_reg;
    logic [KW-1:0]        key_reg, bkey_reg;
    logic [TW-1:0]        tag_reg, btag_reg;
    rtpq_pkg::link_t      cur_reg, par_reg, best_reg, bpar_reg;
    logic                 side_reg, bside_reg;
    logic [rtpq_pkg::LEVEL_W-1:0] lvl_reg;
    rtpq_pkg::node_t      prev_reg;   // contents of the node at par_reg
    rtpq_pkg::node_t      bprev_reg;  // contents of the parent of the best node
    logic [2:0]           ost_reg;
    logic [KW-1:0]        okey_reg;
    logic [TW-1:0]        otag_reg;
    logic                 ov_reg;

    wire [2:0]    in_op  = s_axis_tdata[2:0];
    wire [KW-1:0] in_key = s_axis_tdata[66:3];
    wire [TW-1:0] in_tag = s_axis_tdata[98:67];

    assign s_axis_tready = (state_reg == S_IDLE) && !ov_reg;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {5'd0, otag_reg, okey_reg, ost_reg};

    wire cur_is_node = !cur_reg[IW];
    wire kbit = key_reg[6'(63 - lvl_reg[5:0])];
    wire rd_c0_node = !node_rd.c0[IW];
    wire rd_c1_node = !node_rd.c1[IW];
    wire rd_leaf = !rd_c0_node && !rd_c1_node;
    wire first_lvl = (lvl_reg == '0);
    wire min_better = best_reg[IW] || (node_rd.key < bkey_reg);

    // memory access decode
    always_comb
    begin
        node_ra = cur_reg[IW-1:0];
        free_ra = head_reg[IW-1:0];
        node_we = 1'b0;
        node_wa = cur_reg[IW-1:0];
        node_wd = node_rd;
        free_we = 1'b0;
        free_wa = cur_reg[IW-1:0];
        free_wd = head_reg;
        case (state_reg)
            S_INIT:
            begin
                free_we = 1'b1;
                free_wd = cur_reg + 1'b1;
            end
            S_FIND:
            begin
                // insert at empty link: write new node at free head
                if (!cur_is_node && op_reg == rtpq_pkg::OP_INSERT)
                begin
                    node_we = 1'b1;
                    node_wa = head_reg[IW-1:0];
                    node_wd = '{key: key_reg, tag: tag_reg,
                                c0: rtpq_pkg::NIL, c1: rtpq_pkg::NIL};
                end
                else if (cur_is_node && node_rd.key == key_reg
                         && op_reg == rtpq_pkg::OP_MODIFY)
                begin
                    node_we = 1'b1;
                    node_wd = node_rd;
                    node_wd.tag = tag_reg;
                end
            end
            S_LINK:
            begin
                // hook the new node into its parent
                node_we = 1'b1;
                node_wa = par_reg[IW-1:0];
                node_wd = prev_reg;
                if (side_reg)
                    node_wd.c1 = best_reg;
                else
                    node_wd.c0 = best_reg;
            end
            S_RMV:
            begin
                // below the first level the parent takes this node's entry
                node_wa = par_reg[IW-1:0];
                node_wd = prev_reg;
                if (!first_lvl)
                begin
                    node_wd.key = node_rd.key;
                    node_wd.tag = node_rd.tag;
                end
                if (rd_leaf)
                begin
                    // leaf: free it and cut the parent link
                    free_we = 1'b1;
                    if (side_reg)
                        node_wd.c1 = rtpq_pkg::NIL;
                    else
                        node_wd.c0 = rtpq_pkg::NIL;
                    node_we = !par_reg[IW];
                end
                else
                    node_we = !first_lvl;
            end
            default:
            begin
            end
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            root_reg  <= rtpq_pkg::NIL;
            head_reg  <= '0;
            count_reg <= '0;
            op_reg    <= rtpq_pkg::OP_INSERT;
            key_reg   <= '0;
            tag_reg   <= '0;
            bkey_reg  <= '0;
            btag_reg  <= '0;
            cur_reg   <= '0;
            par_reg   <= rtpq_pkg::NIL;
            best_reg  <= rtpq_pkg::NIL;
            bpar_reg  <= rtpq_pkg::NIL;
            side_reg  <= 1'b0;
            bside_reg <= 1'b0;
            lvl_reg   <= '0;
            prev_reg  <= '0;
            bprev_reg <= '0;
            ost_reg   <= '0;
            okey_reg  <= '0;
            otag_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (ov_reg && m_axis_tready)
                ov_reg <= 1'b0;
            case (state_reg)
                S_INIT:
                begin
                    cur_reg <= cur_reg + 1'b1;
                    if (cur_reg == LW'(rtpq_pkg::CAPACITY - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        op_reg   <= rtpq_pkg::op_t'(in_op);
                        key_reg  <= in_key;
                        tag_reg  <= in_tag;
                        cur_reg  <= root_reg;
                        par_reg  <= rtpq_pkg::NIL;
                        side_reg <= 1'b0;
                        lvl_reg  <= '0;
                        best_reg <= rtpq_pkg::NIL;
                        ost_reg  <= rtpq_pkg::ST_OK;
                        okey_reg <= '0;
                        otag_reg <= '0;
                        case (in_op)
                            rtpq_pkg::OP_INSERT:
                            begin
                                if (count_reg >= LW'(rtpq_pkg::CAPACITY) || head_reg[IW])
                                begin
                                    ost_reg   <= rtpq_pkg::ST_FULL;
                                    state_reg <= S_OUT;
                                end
                                else
                                    state_reg <= S_FRD;
                            end
                            rtpq_pkg::OP_MODIFY, rtpq_pkg::OP_LOOKUP,
                            rtpq_pkg::OP_DELETE:
                                state_reg <= S_FRD;
                            rtpq_pkg::OP_PEEK, rtpq_pkg::OP_POP:
                            begin
                                if (count_reg == '0 || root_reg[IW])
                                begin
                                    ost_reg   <= rtpq_pkg::ST_EMPTY;
                                    state_reg <= S_OUT;
                                end
                                else
                                    state_reg <= S_MRD;
                            end
                            default:
                                state_reg <= S_OUT;
                        endcase
                    end
                end
                // key search: issue read of cur
                S_FRD:
                    state_reg <= S_FIND;
                S_FIND:
                begin
                    if (!cur_is_node)
                    begin
                        if (op_reg == rtpq_pkg::OP_INSERT)
                        begin
                            count_reg <= count_reg + 1'b1;
                            head_reg  <= free_rd;
                            if (par_reg[IW])
                            begin
                                root_reg  <= head_reg;
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                // new node index kept for the parent write
                                best_reg  <= head_reg;
                                state_reg <= S_LINK;
                            end
                        end
                        else
                        begin
                            ost_reg   <= rtpq_pkg::ST_NOTFOUND;
                            state_reg <= S_OUT;
                        end
                    end
                    else if (node_rd.key == key_reg)
                    begin
                        case (op_reg)
                            rtpq_pkg::OP_INSERT:
                            begin
                                ost_reg   <= rtpq_pkg::ST_DUP;
                                state_reg <= S_OUT;
                            end
                            rtpq_pkg::OP_LOOKUP:
                            begin
                                otag_reg  <= node_rd.tag;
                                state_reg <= S_OUT;
                            end
                            rtpq_pkg::OP_DELETE:
                            begin
                                if (count_reg != '0)
                                    count_reg <= count_reg - 1'b1;
                                lvl_reg   <= '0;
                                state_reg <= S_RRD;
                            end
                            default:
                                state_reg <= S_OUT;
                        endcase
                    end
                    else if (lvl_reg >= 7'd64)
                    begin
                        ost_reg   <= (op_reg == rtpq_pkg::OP_INSERT)
                                     ? rtpq_pkg::ST_DUP : rtpq_pkg::ST_NOTFOUND;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        prev_reg  <= node_rd;
                        par_reg   <= cur_reg;
                        side_reg  <= kbit;
                        cur_reg   <= kbit ? node_rd.c1 : node_rd.c0;
                        lvl_reg   <= lvl_reg + 1'b1;
                        state_reg <= S_FRD;
                    end
                end
                S_LINK:
                    state_reg <= S_OUT;
                // minimum walk
                S_MRD:
                    state_reg <= S_MIN;
                S_MIN:
                begin
                    if (min_better)
                    begin
                        best_reg  <= cur_reg;
                        bkey_reg  <= node_rd.key;
                        btag_reg  <= node_rd.tag;
                        bpar_reg  <= par_reg;
                        bside_reg <= side_reg;
                        bprev_reg <= prev_reg;
                    end
                    prev_reg <= node_rd;
                    par_reg  <= cur_reg;
                    side_reg <= !rd_c0_node;
                    cur_reg  <= rd_c0_node ? node_rd.c0 : node_rd.c1;
                    lvl_reg  <= lvl_reg + 1'b1;
                    if (rd_leaf || lvl_reg >= 7'd64)
                    begin
                        if (min_better)
                        begin
                            okey_reg <= node_rd.key;
                            otag_reg <= node_rd.tag;
                        end
                        else
                        begin
                            okey_reg <= bkey_reg;
                            otag_reg <= btag_reg;
                        end
                        if (op_reg == rtpq_pkg::OP_POP)
                        begin
                            // remove the minimum from its link
                            count_reg <= count_reg - 1'b1;
                            lvl_reg   <= '0;
                            if (min_better)
                            begin
                                cur_reg  <= cur_reg;
                                par_reg  <= par_reg;
                                side_reg <= side_reg;
                                prev_reg <= prev_reg;
                            end
                            else
                            begin
                                cur_reg  <= best_reg;
                                par_reg  <= bpar_reg;
                                side_reg <= bside_reg;
                                prev_reg <= bprev_reg;
                            end
                            state_reg <= S_RRD;
                        end
                        else
                            state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_MRD;
                end
                // removal walk
                S_RRD:
                    state_reg <= S_RMV;
                S_RMV:
                begin
                    if (rd_leaf)
                    begin
                        head_reg <= cur_reg;
                        if (par_reg[IW])
                            root_reg <= rtpq_pkg::NIL;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        prev_reg  <= node_rd;
                        par_reg   <= cur_reg;
                        side_reg  <= !rd_c0_node;
                        cur_reg   <= rd_c0_node ? node_rd.c0 : node_rd.c1;
                        lvl_reg   <= lvl_reg + 1'b1;
                        state_reg <= S_RRD;
                    end
                end
                S_OUT:
                begin
                    ov_reg    <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
